>>> src/deadline_ordered_timer_queue_macros.svh
// Assertion macros for the sorted timer queue checker.
// Expect signals clk and arst_n in the including scope.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DOTQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dotq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define DOTQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dotq: next-cycle check failed");

`endif

>>> src/dotq_pkg.sv
// Shared types and codes for the sorted timer queue.
// No dependencies; used by every module of the block.
`default_nettype none

package dotq_pkg;

	localparam int ID_W       = 4;
	localparam int DELAY_W    = 32;
	localparam int DEADLINE_W = 64;

	typedef enum logic {
		REQ_ARM    = 1'b0,
		REQ_CANCEL = 1'b1
	} dotq_req_type_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_MISS = 2'd3
	} dotq_status_t;

	typedef enum logic {
		FSM_IDLE  = 1'b0,
		FSM_APPLY = 1'b1
	} dotq_fsm_t;

	typedef struct packed {
		dotq_req_type_t          req_type;
		logic [ID_W-1:0]         timer_id;
		logic [DELAY_W-1:0]      delay;
		logic [DEADLINE_W-1:0]   now;
	} dotq_req_t;

	typedef struct packed {
		dotq_status_t            status;
		logic                    reprogram;
		logic [ID_W-1:0]         head_id;
		logic [DEADLINE_W-1:0]   head_deadline;
	} dotq_res_t;

	typedef struct packed {
		logic [DEADLINE_W-1:0]   deadline;
		logic [ID_W-1:0]         owner;
	} dotq_entry_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic        capture;
		logic        arm;
		logic        cancel;
		dotq_entry_t key;
	} dotq_cell_cmd_t;

endpackage

`default_nettype wire

>>> src/deadline_ordered_timer_queue.sv
// Sorted timer queue: a row of QUEUE_DEPTH cells kept in deadline order.
// The result of a request is registered at the edge after the one that accepts it.
// No new request is taken until the last has passed the capture edge and then the shift edge of the row;
// a result left waiting under res_stall holds the input off until it is taken.
// Reset (arst_n, asynchronous): queue empty, no timer queued, device_mode one-shot.
// Depends on dotq_pkg and dotq_cell; slot contents have no reset and hold no valid entry until an arm fills them.
`default_nettype none

module deadline_ordered_timer_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIMER_COUNT = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        req_valid,
	output logic                       req_stall,
	input  wire dotq_pkg::dotq_req_t   req,
	output logic                       res_valid,
	input  wire                        res_stall,
	output dotq_pkg::dotq_res_t        res,
	input  wire                        cfg_we,
	input  wire                        cfg_wdata
);

	// Index of a slot, slot count and index of a timer flag
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int FW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	// Control and configuration
	dotq_pkg::dotq_fsm_t    state_q;
	dotq_pkg::dotq_fsm_t    state_d;
	logic                   mode_q;
	logic [OW-1:0]          occ_q;
	logic [TIMER_COUNT-1:0] flags_q;

	// Request held across the apply cycle
	dotq_pkg::dotq_req_type_t kind_q;
	dotq_pkg::dotq_entry_t    key_q;

	// Result register
	dotq_pkg::dotq_res_t res_q;
	logic                res_valid_q;

	// Decode of the held request
	logic                     accept;
	logic                     res_wait;
	dotq_pkg::dotq_entry_t    key_in;
	dotq_pkg::dotq_cell_cmd_t cmd;
	logic                     id_ok;
	logic [FW-1:0]            flag_idx;
	logic                     queued;
	logic                     full;
	logic                     arm_ok;
	logic                     cancel_ok;
	logic [QW-1:0]            cut;
	dotq_pkg::dotq_res_t      res_d;

	// Links along the cell row
	wire [QUEUE_DEPTH-1:0]      gt_w;
	wire [QUEUE_DEPTH-1:0]      hit_w;
	wire [QUEUE_DEPTH-1:0]      left_gt_w;
	wire dotq_pkg::dotq_entry_t ent_w [QUEUE_DEPTH];
	wire dotq_pkg::dotq_entry_t left_ent_w [QUEUE_DEPTH];
	wire dotq_pkg::dotq_entry_t right_ent_w [QUEUE_DEPTH];

	// Absolute deadline of the incoming request; the sum wraps at 64 bits
	assign key_in.deadline = req.now +
		{{(dotq_pkg::DEADLINE_W - dotq_pkg::DELAY_W){1'b0}}, req.delay};
	assign key_in.owner    = req.timer_id;

	// A result that is offered and not taken holds the input off
	assign res_wait = res_valid_q && res_stall;

	// Next state, input stall and the command broadcast to every cell
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		cmd       = '0;
		unique case (state_q)
			dotq_pkg::FSM_IDLE: begin
				// Capture: every cell compares its entry with the new key
				req_stall   = res_wait;
				cmd.capture = req_valid && !res_wait;
				cmd.key     = key_in;
				if (req_valid && !res_wait) begin
					state_d = dotq_pkg::FSM_APPLY;
				end
			end
			dotq_pkg::FSM_APPLY: begin
				// Shift: open a slot for an arm, close the gap for a cancel
				cmd.arm    = (kind_q == dotq_pkg::REQ_ARM) && arm_ok;
				cmd.cancel = (kind_q == dotq_pkg::REQ_CANCEL) && cancel_ok;
				cmd.key    = key_q;
				state_d    = dotq_pkg::FSM_IDLE;
			end
			default: begin
				state_d = dotq_pkg::FSM_IDLE;
			end
		endcase
	end

	assign accept = cmd.capture;

	// Ids at or above TIMER_COUNT can never be queued
	assign id_ok     = {{(32 - dotq_pkg::ID_W){1'b0}}, key_q.owner} < 32'(TIMER_COUNT);
	assign flag_idx  = FW'(key_q.owner);
	assign queued    = id_ok && flags_q[flag_idx];
	assign full      = occ_q == OW'(QUEUE_DEPTH);
	assign arm_ok    = id_ok && !full && !queued;
	assign cancel_ok = queued;

	// Slot that holds the cancelled id; at most one cell reports a hit
	always_comb begin
		cut = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (hit_w[i]) begin
				cut = QW'(i);
			end
		end
	end

	// Result of the held request; head fields stay zero without a reprogram
	always_comb begin
		res_d = '0;
		if (kind_q == dotq_pkg::REQ_ARM) begin
			if (!id_ok || full) begin
				res_d.status = dotq_pkg::ST_FULL;
			end else if (queued) begin
				res_d.status = dotq_pkg::ST_DUP;
			end else begin
				res_d.status = dotq_pkg::ST_OK;
				// New head when the queue was empty or the old head is later
				if (!mode_q && (occ_q == '0 || gt_w[0])) begin
					res_d.reprogram     = 1'b1;
					res_d.head_id       = key_q.owner;
					res_d.head_deadline = key_q.deadline;
				end
			end
		end else begin
			if (!cancel_ok) begin
				res_d.status = dotq_pkg::ST_MISS;
			end else begin
				res_d.status = dotq_pkg::ST_OK;
				// Head cancelled with entries left: the second slot moves up
				if (!mode_q && hit_w[0] && occ_q > OW'(1)) begin
					res_d.reprogram     = 1'b1;
					res_d.head_id       = ent_w[1].owner;
					res_d.head_deadline = ent_w[1].deadline;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dotq_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Device mode may be written at any edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Hold the request for the apply cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= dotq_pkg::REQ_ARM;
			key_q  <= '0;
		end else if (accept) begin
			kind_q <= req.req_type;
			key_q  <= key_in;
		end
	end

	// Advance the slot count and the per-id flags with the shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			flags_q <= '0;
		end else if (cmd.arm) begin
			occ_q             <= occ_q + OW'(1);
			flags_q[flag_idx] <= 1'b1;
		end else if (cmd.cancel) begin
			occ_q             <= occ_q - OW'(1);
			flags_q[flag_idx] <= 1'b0;
		end
	end

	// Register the result; hold it until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (state_q == dotq_pkg::FSM_APPLY) begin
			res_q       <= res_d;
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	// Row of cells; each sees its left and right neighbour only
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign left_ent_w[g] = '0;
			assign left_gt_w[g]  = 1'b0;
		end else begin : g_link
			assign left_ent_w[g] = ent_w[g-1];
			assign left_gt_w[g]  = gt_w[g-1];
		end
		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign right_ent_w[g] = '0;
		end else begin : g_next
			assign right_ent_w[g] = ent_w[g+1];
		end

		dotq_cell #(
			.INDEX(g),
			.QW(QW),
			.OW(OW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.occ(occ_q),
			.cut(cut),
			.left_ent(left_ent_w[g]),
			.left_gt(left_gt_w[g]),
			.right_ent(right_ent_w[g]),
			.ent(ent_w[g]),
			.gt(gt_w[g]),
			.hit(hit_w[g])
		);
	end

endmodule

`default_nettype wire

>>> src/dotq_cell.sv
// One slot of the sorted queue: entry, compare flags and neighbour shifting.
// Depends on dotq_pkg.
`default_nettype none

module dotq_cell #(
	parameter int INDEX = 0,
	parameter int QW    = 4,
	parameter int OW    = 5
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire dotq_pkg::dotq_cell_cmd_t    cmd,
	input  wire [OW-1:0]                     occ,
	input  wire [QW-1:0]                     cut,
	input  wire dotq_pkg::dotq_entry_t       left_ent,
	input  wire                              left_gt,
	input  wire dotq_pkg::dotq_entry_t       right_ent,
	output dotq_pkg::dotq_entry_t            ent,
	output logic                             gt,
	output logic                             hit
);

	dotq_pkg::dotq_entry_t ent_q;
	logic gt_q;
	logic hit_q;
	logic valid;
	logic at_tail;
	logic cut_here;

	assign valid    = OW'(INDEX) < occ;
	assign at_tail  = OW'(INDEX) == occ;
	assign cut_here = QW'(INDEX) >= cut;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q  <= 1'b0;
			hit_q <= 1'b0;
		end else if (cmd.capture) begin
			gt_q  <= valid && (ent_q.deadline > cmd.key.deadline);
			hit_q <= valid && (ent_q.owner == cmd.key.owner);
		end
	end

	// Make room on arm, close the gap on cancel
	always_ff @(posedge clk) begin
		if (cmd.arm && (gt_q || at_tail)) begin
			ent_q <= left_gt ? left_ent : cmd.key;
		end else if (cmd.cancel && cut_here) begin
			ent_q <= right_ent;
		end
	end

	assign ent = ent_q;
	assign gt  = gt_q;
	assign hit = hit_q;

endmodule

`default_nettype wire

>>> src/dotq_checker.sv
// Port-level checker for the sorted timer queue, bound to the top level.
// Depends on dotq_pkg and deadline_ordered_timer_queue_macros.svh.
`default_nettype none
`include "deadline_ordered_timer_queue_macros.svh"

module dotq_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       req_valid,
	input wire                       req_stall,
	input wire                       res_valid,
	input wire                       res_stall,
	input wire dotq_pkg::dotq_res_t  res
);

	// A request occupies the cell row for the following cycle
	`DOTQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

	// Head fields are zero unless a reprogram is asked for
	`DOTQ_ASSERT_NOW(a_head_zero, res_valid && !res.reprogram, {res.head_id, res.head_deadline} == '0)

	// Only a successful request can move the head
	`DOTQ_ASSERT_NOW(a_reprogram_ok, res_valid && res.reprogram, res.status == dotq_pkg::ST_OK)

	// A waiting result holds until taken
	`DOTQ_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

endmodule

bind deadline_ordered_timer_queue dotq_checker u_dotq_checker (.*);

`default_nettype wire

>>> tb/tb_deadline_ordered_timer_queue.sv
// Self-checking bench for deadline_ordered_timer_queue: directed table, then random requests.
// Results are checked against a bench queue model or written-in values, under varied idling.
// Depends on dotq_pkg and the RTL of the block only.

module tb_deadline_ordered_timer_queue;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIMER_COUNT = 16;
	localparam bit MODE_ONE_SHOT = 1'b0;
	localparam bit MODE_PERIODIC = 1'b1;
	localparam int PHASE_COUNT = 7;
	localparam int PHASE_REQUESTS = 240;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	dotq_pkg::dotq_req_t req;
	logic res_valid;
	logic res_stall;
	dotq_pkg::dotq_res_t res;
	logic cfg_we;
	logic cfg_wdata;

	// Bench copy of the queue: deadlines and owners in sorted order, plus per-id flags
	logic [dotq_pkg::DEADLINE_W-1:0] pend_deadline [QUEUE_DEPTH];
	logic [dotq_pkg::ID_W-1:0] pend_owner [QUEUE_DEPTH];
	int pend_count = 0;
	bit armed [TIMER_COUNT];
	bit device_mode_model = MODE_ONE_SHOT;

	dotq_pkg::dotq_res_t expected_results [$];
	int mismatch_count = 0;

	// Idling knobs; the receiver side runs in its own process below
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int holdoff_request = 0;
	int holdoff_left = 0;

	typedef struct {
		dotq_pkg::dotq_req_t rq;
		bit typed;
		dotq_pkg::dotq_res_t want;
	} timer_row_t;

	timer_row_t timer_rows [$];

	deadline_ordered_timer_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TIMER_COUNT(TIMER_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Apply one request to the bench queue and return the result it should produce
	function automatic dotq_pkg::dotq_res_t apply_timer_request(input dotq_pkg::dotq_req_t r);
		dotq_pkg::dotq_res_t outcome;
		logic [dotq_pkg::DEADLINE_W-1:0] dl;
		int pos;
		int k;
		outcome = '0;
		if (r.req_type == dotq_pkg::REQ_ARM) begin
			if (r.timer_id >= TIMER_COUNT || pend_count >= QUEUE_DEPTH) begin
				outcome.status = dotq_pkg::ST_FULL;
			end else if (armed[r.timer_id]) begin
				outcome.status = dotq_pkg::ST_DUP;
			end else begin
				dl = r.now + {{(dotq_pkg::DEADLINE_W-dotq_pkg::DELAY_W){1'b0}}, r.delay};
				// Equal deadlines go behind the ones already queued
				pos = 0;
				while (pos < pend_count && pend_deadline[pos] <= dl)
					pos++;
				for (k = pend_count; k > pos; k--) begin
					pend_deadline[k] = pend_deadline[k-1];
					pend_owner[k] = pend_owner[k-1];
				end
				pend_deadline[pos] = dl;
				pend_owner[pos] = r.timer_id;
				pend_count++;
				armed[r.timer_id] = 1'b1;
				outcome.status = dotq_pkg::ST_OK;
				if (device_mode_model == MODE_ONE_SHOT && pos == 0) begin
					outcome.reprogram = 1'b1;
					outcome.head_id = r.timer_id;
					outcome.head_deadline = dl;
				end
			end
		end else begin
			pos = 0;
			while (pos < pend_count && pend_owner[pos] != r.timer_id)
				pos++;
			if (r.timer_id >= TIMER_COUNT || !armed[r.timer_id] || pos >= pend_count) begin
				outcome.status = dotq_pkg::ST_MISS;
			end else begin
				// Close the gap; the entries behind move up one slot
				for (k = pos; k + 1 < pend_count; k++) begin
					pend_deadline[k] = pend_deadline[k+1];
					pend_owner[k] = pend_owner[k+1];
				end
				pend_count--;
				armed[r.timer_id] = 1'b0;
				outcome.status = dotq_pkg::ST_OK;
				// A new head only when the old one went and something is left
				if (device_mode_model == MODE_ONE_SHOT && pos == 0 && pend_count > 0) begin
					outcome.reprogram = 1'b1;
					outcome.head_id = pend_owner[0];
					outcome.head_deadline = pend_deadline[0];
				end
			end
		end
		return outcome;
	endfunction

	function automatic void add_row(input dotq_pkg::dotq_req_type_t kind,
			input logic [dotq_pkg::ID_W-1:0] id,
			input logic [dotq_pkg::DELAY_W-1:0] dly,
			input logic [dotq_pkg::DEADLINE_W-1:0] at, input bit typed,
			input dotq_pkg::dotq_status_t st, input logic rep,
			input logic [dotq_pkg::ID_W-1:0] hid,
			input logic [dotq_pkg::DEADLINE_W-1:0] hdl);
		timer_row_t row;
		row.rq.req_type = kind;
		row.rq.timer_id = id;
		row.rq.delay = dly;
		row.rq.now = at;
		row.typed = typed;
		row.want.status = st;
		row.want.reprogram = rep;
		row.want.head_id = hid;
		row.want.head_deadline = hdl;
		timer_rows.push_back(row);
	endfunction

	// Random request; while filling, arms dominate and mostly pick free ids,
	// while draining, cancels dominate and mostly hit queued ids
	function automatic dotq_pkg::dotq_req_t make_timer_request(input bit filling);
		dotq_pkg::dotq_req_t r;
		logic [dotq_pkg::ID_W-1:0] id;
		int k;
		if ($urandom_range(0, 99) < (filling ? 80 : 25))
			r.req_type = dotq_pkg::REQ_ARM;
		else
			r.req_type = dotq_pkg::REQ_CANCEL;
		id = dotq_pkg::ID_W'($urandom_range(0, TIMER_COUNT - 1));
		if (r.req_type == dotq_pkg::REQ_ARM) begin
			if (pend_count < QUEUE_DEPTH && $urandom_range(0, 99) < 85) begin
				for (k = 0; k < TIMER_COUNT; k++)
					if (armed[id])
						id = id + 1'b1;
			end
		end else if (pend_count > 0 && $urandom_range(0, 99) < 80) begin
			id = pend_owner[$urandom_range(0, pend_count - 1)];
		end
		r.timer_id = id;
		case ($urandom_range(0, 9))
			0: r.delay = '0;
			1: r.delay = '1;
			2, 3, 4: r.delay = dotq_pkg::DELAY_W'($urandom_range(0, 7));
			default: r.delay = $urandom;
		endcase
		// Small times give equal deadlines; times near the top wrap past zero
		case ($urandom_range(0, 9))
			0, 1, 2, 3: r.now = dotq_pkg::DEADLINE_W'($urandom_range(0, 15));
			4, 5: r.now = 64'hFFFF_FFFF_FFFF_FFF0 +
				dotq_pkg::DEADLINE_W'($urandom_range(0, 15));
			default: r.now = {$urandom, $urandom};
		endcase
		return r;
	endfunction

	// Offer one request after a random gap, hold it until taken, then predict
	task automatic send_request(input dotq_pkg::dotq_req_t r, input bit typed,
			input dotq_pkg::dotq_res_t want);
		dotq_pkg::dotq_res_t predicted;
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		predicted = apply_timer_request(r);
		expected_results.push_back(typed ? want : predicted);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	// Wait for every outstanding result, then a short pause for the pipeline
	task automatic drain_results();
		int waited;
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			mismatch_count++;
			expected_results.delete();
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic write_device_mode(input bit mode);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		device_mode_model = mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver: random stall, or a long hold-off counted down here
	always @(negedge clk) begin
		if (holdoff_request != 0) begin
			holdoff_left = holdoff_request;
			holdoff_request = 0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Compare every taken result with the oldest expectation
	dotq_pkg::dotq_res_t oldest;
	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result status %0d reprogram %0b head %0h deadline %0h",
					$time, res.status, res.reprogram, res.head_id, res.head_deadline);
				mismatch_count++;
			end else begin
				oldest = expected_results.pop_front();
				check_field("status", 64'(oldest.status), 64'(res.status));
				check_field("reprogram", 64'(oldest.reprogram), 64'(res.reprogram));
				check_field("head_id", 64'(oldest.head_id), 64'(res.head_id));
				check_field("head_deadline", oldest.head_deadline, res.head_deadline);
			end
		end
	end

	// Hard stop should the block hang
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int phase_mode [PHASE_COUNT];
		int phase_idle [PHASE_COUNT];
		int phase_stall [PHASE_COUNT];
		int phase_holdoff [PHASE_COUNT];
		int p;
		int i;
		bit filling;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		res_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		for (i = 0; i < TIMER_COUNT; i++)
			armed[i] = 1'b0;
		for (i = 0; i < QUEUE_DEPTH; i++) begin
			pend_deadline[i] = '0;
			pend_owner[i] = '0;
		end

		// Directed table; the empty queue, duplicates, the full queue and the
		// wrap of the deadline have their results written in
		add_row(dotq_pkg::REQ_CANCEL, 4'd5, '0, '0, 1'b1, dotq_pkg::ST_MISS, 1'b0, 4'd0, 64'd0);
		add_row(dotq_pkg::REQ_ARM, 4'd7, '0, '0, 1'b1, dotq_pkg::ST_OK, 1'b1, 4'd7, 64'd0);
		add_row(dotq_pkg::REQ_ARM, 4'd7, 32'd9, '0, 1'b1, dotq_pkg::ST_DUP, 1'b0, 4'd0, 64'd0);
		// last entry leaves: no head to reprogram for
		add_row(dotq_pkg::REQ_CANCEL, 4'd7, '0, '0, 1'b1, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);
		add_row(dotq_pkg::REQ_ARM, 4'd0, '0, '0, 1'b1, dotq_pkg::ST_OK, 1'b1, 4'd0, 64'd0);
		// largest delay on the largest time wraps to just below 2**32
		add_row(dotq_pkg::REQ_ARM, 4'd15, '1, '1, 1'b1, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);
		add_row(dotq_pkg::REQ_ARM, 4'd1, 32'd5, '0, 1'b0, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);
		// equal deadline to the head: goes behind it
		add_row(dotq_pkg::REQ_ARM, 4'd2, '0, '0, 1'b0, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);
		add_row(dotq_pkg::REQ_ARM, 4'd3, '0, '1, 1'b0, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);
		add_row(dotq_pkg::REQ_CANCEL, 4'd0, '0, '0, 1'b0, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);
		add_row(dotq_pkg::REQ_CANCEL, 4'd1, '0, '0, 1'b0, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);
		add_row(dotq_pkg::REQ_CANCEL, 4'd3, '1, '1, 1'b0, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);
		add_row(dotq_pkg::REQ_CANCEL, 4'd3, '0, '0, 1'b1, dotq_pkg::ST_MISS, 1'b0, 4'd0, 64'd0);
		// fill the remaining slots
		for (i = 0; i < TIMER_COUNT; i++)
			if (i != 2 && i != 15)
				add_row(dotq_pkg::REQ_ARM, dotq_pkg::ID_W'(i), dotq_pkg::DELAY_W'(i * 37),
					64'h8000_0000_0000_0000 - dotq_pkg::DEADLINE_W'(i * 1000),
					1'b0, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);
		// queue full wins over the id being queued already
		add_row(dotq_pkg::REQ_ARM, 4'd9, '0, '0, 1'b1, dotq_pkg::ST_FULL, 1'b0, 4'd0, 64'd0);
		add_row(dotq_pkg::REQ_CANCEL, 4'd2, '0, '0, 1'b0, dotq_pkg::ST_OK, 1'b0, 4'd0, 64'd0);

		// Random phases: mode, sender idle, receiver stall, hold-off
		phase_mode = '{MODE_ONE_SHOT, MODE_PERIODIC, MODE_ONE_SHOT, MODE_PERIODIC,
			MODE_ONE_SHOT, MODE_PERIODIC, MODE_ONE_SHOT};
		phase_idle = '{0, 84, 0, 20, 0, 0, 84};
		phase_stall = '{0, 0, 84, 20, 0, 0, 84};
		phase_holdoff = '{0, 0, 0, 0, HOLDOFF_CYCLES, 0, 0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (timer_rows[r])
			send_request(timer_rows[r].rq, timer_rows[r].typed, timer_rows[r].want);

		for (p = 0; p < PHASE_COUNT; p++) begin
			stop_sending();
			drain_results();
			// Knobs change on a rising edge so the receiver picks them up cleanly
			send_idle_pct = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			holdoff_request = phase_holdoff[p];
			write_device_mode(phase_mode[p][0]);
			filling = 1'b1;
			for (i = 0; i < PHASE_REQUESTS; i++) begin
				// Alternate tides so the queue swings between empty and full
				if (i % 48 == 47)
					filling = !filling;
				send_request(make_timer_request(filling), 1'b0, '0);
			end
		end

		stop_sending();
		drain_results();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/dotq_pkg.sv
src/dotq_cell.sv
src/deadline_ordered_timer_queue.sv
src/dotq_checker.sv
tb/tb_deadline_ordered_timer_queue.sv
